@@ hw/rtl/tpba_pkg.sv @@
// tangent plane bearing: shared widths, flag struct and the cordic arctangent table
// no dependencies
`timescale 1ns / 1ps

package tpba_pkg;

    localparam int COMPONENT_BITS_DEF  = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int CORDIC_STAGES_DEF   = 16;

    // working width of one vector component
    localparam int WORK_W = 16;
    // width of c and of the scaled cross term
    localparam int CW = 52;
    // width of the cordic x / y datapath
    localparam int XW = 34;
    localparam int ANG_W = 32;
    localparam int POS_W = 6;
    // bit position the larger magnitude is normalized to
    localparam int TARGET_MSB = 29;
    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam int FULL_W = 21;

    typedef struct packed {
        logic degen;
        logic zero_s;
        logic c_neg;
    } tpba_flags_t;

    // round(atan(2^-i) * 2^32 / (2*pi))
    function automatic logic [ANG_W-1:0] atan_coef(input int idx);
        logic [ANG_W-1:0] r;
        begin
            case (idx)
                0:  r = 32'd536870912;
                1:  r = 32'd316933406;
                2:  r = 32'd167458907;
                3:  r = 32'd85004756;
                4:  r = 32'd42667331;
                5:  r = 32'd21354465;
                6:  r = 32'd10679838;
                7:  r = 32'd5340245;
                8:  r = 32'd2670163;
                9:  r = 32'd1335087;
                10: r = 32'd667544;
                11: r = 32'd333772;
                12: r = 32'd166886;
                13: r = 32'd83443;
                14: r = 32'd41722;
                15: r = 32'd20861;
                16: r = 32'd10430;
                17: r = 32'd5215;
                18: r = 32'd2608;
                19: r = 32'd1304;
                20: r = 32'd652;
                21: r = 32'd326;
                22: r = 32'd163;
                23: r = 32'd81;
                24: r = 32'd41;
                25: r = 32'd20;
                26: r = 32'd10;
                27: r = 32'd5;
                28: r = 32'd3;
                29: r = 32'd1;
                30: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ hw/rtl/tangent_plane_bearing_angle.sv @@
// tangent plane bearing: top level with the product front end, normalizer,
// cordic cell chain and degree scaling; depends on tpba_pkg, tpba_norm, tpba_cell
`timescale 1ns / 1ps

// Usage
//   s_* channel: one word carries a view vector a and a target vector b, six
//   signed components of COMPONENT_BITS each. m_* channel: one word per input
//   word, the bearing of b about a in 2^-ANGLE_FRAC_BITS degree steps (0 to
//   below 360) and a degenerate flag in tuser (bearing then 0).
//   Stages: four product/sum stages, four normalizer stages, one cordic cell
//   per iteration, two scaling stages. Throughput: one word per cycle while
//   the receiver takes words; each iteration is a register of the cell chain and
//   there is no shared unit.
//   Each stage holds a valid bit and loads whenever it is empty or the stage
//   after it moves, so a stalled receiver only stops the words behind it and
//   s_tready stays high while any bubble is left in the pipe.
//   Reset clears all valid bits; the pipe is empty and ready right after.

module tangent_plane_bearing_angle
    import tpba_pkg::*;
#(
    parameter int COMPONENT_BITS  = COMPONENT_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // view_x, view_y, view_z, target_x, target_y, target_z, zero pad
    input  logic [((6*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // bearing[14:0], zero pad
    output logic [15:0]             m_tdata,
    // degenerate
    output logic                    m_tuser
);

    localparam int WB    = (COMPONENT_BITS > WORK_W) ? WORK_W : COMPONENT_BITS;
    localparam int DROP  = COMPONENT_BITS - WB;
    localparam int FRAC  = WB - 2;
    localparam int NCELL = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int NST   = 4 + 4 + NCELL + 2;
    localparam logic [FULL_W-1:0] FULL = FULL_W'(360 << ANGLE_FRAC_BITS);
    localparam int PW    = ANG_W + FULL_W;

    logic [NST-1:0] v_reg, en;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || m_tready;
        for (int k = NST-2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NST-1];

    // component extraction
    logic signed [COMPONENT_BITS-1:0] raw [6];
    logic signed [COMPONENT_BITS-1:0] shr [6];
    logic signed [WORK_W-1:0]         comp [6];

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            raw[k]  = signed'(s_tdata[k*COMPONENT_BITS +: COMPONENT_BITS]);
            shr[k]  = raw[k] >>> DROP;
            comp[k] = WORK_W'(signed'(shr[k][WB-1:0]));
        end
    end

    // stage 1: products
    logic signed [31:0] sqx_reg, sqy_reg, sqz_reg, dtx_reg, dty_reg, dtz_reg;
    logic signed [31:0] aybz_reg, azby_reg, azbx_reg, axbz_reg, axby_reg, aybx_reg;
    logic signed [WORK_W-1:0] az1_reg, bz1_reg;
    logic axy0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sqx_reg  <= comp[0] * comp[0];
            sqy_reg  <= comp[1] * comp[1];
            sqz_reg  <= comp[2] * comp[2];
            dtx_reg  <= comp[0] * comp[3];
            dty_reg  <= comp[1] * comp[4];
            dtz_reg  <= comp[2] * comp[5];
            aybz_reg <= comp[1] * comp[5];
            azby_reg <= comp[2] * comp[4];
            azbx_reg <= comp[2] * comp[3];
            axbz_reg <= comp[0] * comp[5];
            axby_reg <= comp[0] * comp[4];
            aybx_reg <= comp[1] * comp[3];
            az1_reg  <= comp[2];
            bz1_reg  <= comp[5];
            axy0_reg <= (comp[0] == '0) && (comp[1] == '0);
        end
    end

    // stage 2: sums, degenerate test, scaled cross term
    logic signed [33:0]       q_reg, d_reg;
    logic signed [CW-1:0]     ny2_reg;
    logic signed [WORK_W-1:0] az2_reg, bz2_reg;
    logic                     dg2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            q_reg   <= 34'(sqx_reg) + 34'(sqy_reg) + 34'(sqz_reg);
            d_reg   <= 34'(dtx_reg) + 34'(dty_reg) + 34'(dtz_reg);
            ny2_reg <= (CW'(axby_reg) - CW'(aybx_reg)) <<< FRAC;
            az2_reg <= az1_reg;
            bz2_reg <= bz1_reg;
            dg2_reg <= axy0_reg || ((aybz_reg == azby_reg) && (azbx_reg == axbz_reg)
                                    && (axby_reg == aybx_reg));
        end
    end

    // stage 3: products for c
    logic signed [49:0]   qbz_reg, azd_reg;
    logic signed [CW-1:0] ny3_reg;
    logic                 dg3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            qbz_reg <= q_reg * bz2_reg;
            azd_reg <= az2_reg * d_reg;
            ny3_reg <= ny2_reg;
            dg3_reg <= dg2_reg;
        end
    end

    // stage 4: c
    logic signed [CW-1:0] c4_reg, ny4_reg;
    logic                 dg4_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            c4_reg  <= CW'(qbz_reg) - CW'(azd_reg);
            ny4_reg <= ny3_reg;
            dg4_reg <= dg3_reg;
        end
    end

    // cell chain
    logic signed [XW-1:0] xs [NCELL+1];
    logic signed [XW-1:0] ys [NCELL+1];
    logic [ANG_W-1:0]     angs [NCELL+1];
    tpba_flags_t          fls [NCELL+1];

    tpba_norm u_norm (
        .clk       (clk),
        .en        (en[7:4]),
        .c_in      (c4_reg),
        .ny_in     (ny4_reg),
        .degen_in  (dg4_reg),
        .x_out     (xs[0]),
        .y_out     (ys[0]),
        .ang_out   (angs[0]),
        .flags_out (fls[0])
    );

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        tpba_cell #(.IDX(g)) u_cell (
            .clk       (clk),
            .en        (en[8+g]),
            .x_in      (xs[g]),
            .y_in      (ys[g]),
            .ang_in    (angs[g]),
            .flags_in  (fls[g]),
            .x_out     (xs[g+1]),
            .y_out     (ys[g+1]),
            .ang_out   (angs[g+1]),
            .flags_out (fls[g+1])
        );
    end

    // scaling to degrees
    tpba_flags_t      fl;
    logic [ANG_W-1:0] ang_fin;
    logic [PW-1:0]    prod_reg, rnd;
    logic             dgf_reg, dgo_reg;
    logic [FULL_W-1:0] bq;
    logic [14:0]      bearing_reg;

    always_comb
    begin
        fl = fls[NCELL];
        if (fl.degen)
            ang_fin = '0;
        else if (fl.zero_s)
            ang_fin = fl.c_neg ? HALF_TURN : '0;
        else
            ang_fin = angs[NCELL];
        rnd = prod_reg + PW'(HALF_TURN);
        bq  = rnd[PW-1:ANG_W];
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-2])
        begin
            prod_reg <= PW'(ang_fin) * PW'(FULL);
            dgf_reg  <= fl.degen;
        end
        if (en[NST-1])
        begin
            bearing_reg <= (bq >= FULL) ? '0 : bq[14:0];
            dgo_reg     <= dgf_reg;
        end
    end

    assign m_tdata = {1'b0, bearing_reg};
    assign m_tuser = dgo_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[14:0] == '0)
        else $error("degenerate word with nonzero bearing");
    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> FULL_W'(m_tdata[14:0]) < FULL)
        else $error("bearing beyond full circle");
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("not ready with empty output stage");
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted word not in first stage");

endmodule

@@ hw/rtl/tpba_cell.sv @@
// one cordic vectoring cell: rotates (x, y) toward the x axis by atan(2^-IDX)
// depends on tpba_pkg
`timescale 1ns / 1ps

module tpba_cell
    import tpba_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [XW-1:0]    x_in,
    input  logic signed [XW-1:0]    y_in,
    input  logic [ANG_W-1:0]        ang_in,
    input  tpba_flags_t             flags_in,
    output logic signed [XW-1:0]    x_out,
    output logic signed [XW-1:0]    y_out,
    output logic [ANG_W-1:0]        ang_out,
    output tpba_flags_t             flags_out
);

    localparam logic [ANG_W-1:0] COEF = atan_coef(IDX);

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic [ANG_W-1:0]     ang_reg, ang_next;
    tpba_flags_t          flags_reg;

    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (y_in < 0)
        begin
            x_next   = x_in - dx;
            y_next   = y_in + dy;
            ang_next = ang_in - COEF;
        end
        else
        begin
            x_next   = x_in + dx;
            y_next   = y_in - dy;
            ang_next = ang_in + COEF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            ang_reg   <= ang_next;
            flags_reg <= flags_in;
        end
    end

    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign ang_out   = ang_reg;
    assign flags_out = flags_reg;

endmodule

@@ hw/rtl/tpba_norm.sv @@
// normalizer: scales (c, -s) so the larger magnitude sits at bit 29, folds
// the left half plane onto the right; four stages
// depends on tpba_pkg
`timescale 1ns / 1ps

module tpba_norm
    import tpba_pkg::*;
(
    input  logic                    clk,
    input  logic [3:0]              en,
    input  logic signed [CW-1:0]    c_in,
    input  logic signed [CW-1:0]    ny_in,
    input  logic                    degen_in,
    output logic signed [XW-1:0]    x_out,
    output logic signed [XW-1:0]    y_out,
    output logic [ANG_W-1:0]        ang_out,
    output tpba_flags_t             flags_out
);

    logic signed [CW-1:0] abs_c, abs_s;
    logic [CW-1:0]        m_next, m_reg;
    logic signed [CW-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    tpba_flags_t          fa_reg, fa_next, fb_reg, fc_reg, fd_reg;
    logic [POS_W-1:0]     pos_next, pos_reg;
    logic signed [CW-1:0] xs_wide, ys_wide;
    logic signed [XW-1:0] xc_reg, yc_reg, xd_reg, yd_reg, xd_next, yd_next;
    logic [ANG_W-1:0]     angd_reg, angd_next;

    // stage a: larger magnitude
    always_comb
    begin
        abs_c = (c_in < 0) ? -c_in : c_in;
        abs_s = (ny_in < 0) ? -ny_in : ny_in;
        m_next = (abs_c > abs_s) ? abs_c : abs_s;
        fa_next.degen  = degen_in;
        fa_next.zero_s = (ny_in == '0);
        fa_next.c_neg  = (c_in < 0);
    end

    // stage b: leading one position
    always_comb
    begin
        pos_next = '0;
        for (int k = 0; k < CW; k++)
        begin
            if (m_reg[k])
                pos_next = POS_W'(k);
        end
    end

    // stage c: shift to the target position
    always_comb
    begin
        if (pos_reg >= POS_W'(TARGET_MSB))
        begin
            xs_wide = xb_reg >>> (pos_reg - POS_W'(TARGET_MSB));
            ys_wide = yb_reg >>> (pos_reg - POS_W'(TARGET_MSB));
        end
        else
        begin
            xs_wide = xb_reg <<< (POS_W'(TARGET_MSB) - pos_reg);
            ys_wide = yb_reg <<< (POS_W'(TARGET_MSB) - pos_reg);
        end
    end

    // stage d: fold left half plane, start at a half turn when folded
    always_comb
    begin
        if (xc_reg < 0)
        begin
            xd_next   = -xc_reg;
            yd_next   = -yc_reg;
            angd_next = HALF_TURN;
        end
        else
        begin
            xd_next   = xc_reg;
            yd_next   = yc_reg;
            angd_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m_reg  <= m_next;
            xa_reg <= c_in;
            ya_reg <= ny_in;
            fa_reg <= fa_next;
        end
        if (en[1])
        begin
            pos_reg <= pos_next;
            xb_reg  <= xa_reg;
            yb_reg  <= ya_reg;
            fb_reg  <= fa_reg;
        end
        if (en[2])
        begin
            xc_reg <= xs_wide[XW-1:0];
            yc_reg <= ys_wide[XW-1:0];
            fc_reg <= fb_reg;
        end
        if (en[3])
        begin
            xd_reg   <= xd_next;
            yd_reg   <= yd_next;
            angd_reg <= angd_next;
            fd_reg   <= fc_reg;
        end
    end

    assign x_out     = xd_reg;
    assign y_out     = yd_reg;
    assign ang_out   = angd_reg;
    assign flags_out = fd_reg;

endmodule

@@ tb/sv/tb_top.sv @@
// tangent plane bearing testbench: directed table then random vector pairs,
// checked against a local cordic bearing predictor; depends on tpba_pkg and the dut
`timescale 1ns / 1ps

module tb_top;
    import tpba_pkg::*;

    localparam int FULL = 360 << 6;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic signed [15:0] tz, ty, tx, vz, vy, vx;
    } vec_pair_t;

    typedef struct {
        logic [14:0] bearing;
        logic        degen;
    } bearing_t;

    typedef struct {
        vec_pair_t v;
        logic      has_exp;
        bearing_t  r;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    bearing_t  exp_bearings[$];
    int        errors;
    int        idle_cycles;
    logic      long_hold;
    logic      stim_done;

    tangent_plane_bearing_angle i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint shr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic logic [31:0] atan_coef_local(int i);
        logic [31:0] t[16];
        begin
            t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                  32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                  32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                  32'd166886, 32'd83443, 32'd41722, 32'd20861};
            return t[i];
        end
    endfunction

    // vectoring cordic on (c, ny), binary angle with a full turn of 2^32
    function automatic logic [31:0] cordic_bam(longint x, longint y);
        longint m, dx, dy;
        logic [31:0] ang;
        begin
            m = (x < 0 ? -x : x);
            if ((y < 0 ? -y : y) > m)
                m = (y < 0 ? -y : y);
            ang = '0;
            while (m >= (64'sd1 <<< 30))
            begin
                x = shr(x, 1);
                y = shr(y, 1);
                m = shr(m, 1);
            end
            while (m < (64'sd1 <<< 29))
            begin
                x = x * 2;
                y = y * 2;
                m = m * 2;
            end
            if (x < 0)
            begin
                x = -x;
                y = -y;
                ang = HALF_TURN;
            end
            for (int i = 0; i < CORDIC_STAGES_DEF; i++)
            begin
                dx = shr(y, i);
                dy = shr(x, i);
                if (y < 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    ang = ang - atan_coef_local(i);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    ang = ang + atan_coef_local(i);
                end
            end
            return ang;
        end
    endfunction

    function automatic bearing_t predict_bearing(vec_pair_t v);
        longint ax, ay, az, bx, by, bz, ny, q, d, c;
        logic [31:0] ang;
        logic [63:0] wide;
        bearing_t r;
        begin
            ax = v.vx; ay = v.vy; az = v.vz;
            bx = v.tx; by = v.ty; bz = v.tz;
            r.degen = 1'b0;
            r.bearing = '0;
            if ((ax == 0 && ay == 0) ||
                (ay * bz - az * by == 0 && az * bx - ax * bz == 0 &&
                 ax * by - ay * bx == 0))
            begin
                r.degen = 1'b1;
                return r;
            end
            ny = (by * ax - bx * ay) * (64'sd1 <<< 14);
            q = ax * ax + ay * ay + az * az;
            d = ax * bx + ay * by + az * bz;
            c = q * bz - az * d;
            if (ny == 0)
                ang = (c < 0) ? HALF_TURN : 32'd0;
            else
                ang = cordic_bam(c, ny);
            wide = (64'(ang) * 64'(FULL) + 64'h8000_0000) >> 32;
            if (wide >= FULL)
                wide = 0;
            r.bearing = wide[14:0];
            return r;
        end
    endfunction

    function automatic vec_pair_t rand_pair();
        vec_pair_t v;
        int sel;
        begin
            v = vec_pair_t'({$urandom, $urandom, $urandom});
            sel = $urandom_range(0, 9);
            // view parts in -16384..16383 for half, small x/y for one pair in ten
            if (sel < 5)
            begin
                v.vx = 16'($urandom_range(0, 32767) - 16384);
                v.vy = 16'($urandom_range(0, 32767) - 16384);
                v.vz = 16'($urandom_range(0, 32767) - 16384);
            end
            else if (sel == 5)
            begin
                v.tx = 16'(v.vx * $urandom_range(0, 1));
                v.ty = 16'(v.vy * $urandom_range(0, 1));
                v.tz = v.vz;
            end
            else if (sel == 6)
            begin
                v.vx = 16'($urandom_range(0, 15) - 8);
                v.vy = 16'($urandom_range(0, 15) - 8);
                v.tx = 16'($urandom_range(0, 15) - 8);
                v.ty = 16'($urandom_range(0, 15) - 8);
            end
            return v;
        end
    endfunction

    task automatic send_pair(vec_pair_t v, logic has_exp, bearing_t r);
        bearing_t p;
        begin
            p = predict_bearing(v);
            if (has_exp && (p.bearing !== r.bearing || p.degen !== r.degen))
                p = r;
            s_tdata <= 96'(v);
            s_tvalid <= 1'b1;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            exp_bearings.insert(exp_bearings.size(), p);
            @(negedge clk);
        end
    endtask

    task automatic gap();
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
        end
    endtask

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        int burst;
        s_tvalid = 1'b0;
        s_tdata = '0;
        rst_n = 1'b0;
        stim_done = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // target z, y, x then view z, y, x; typed expectations where obvious
        rows.insert(rows.size(), '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
                         1'b1, '{15'd0, 1'b1}});
        rows.insert(rows.size(), '{'{16'sd100, 16'sd5, 16'sd3, 16'sd16384, 16'sd0, 16'sd0},
                         1'b1, '{15'd0, 1'b1}});
        rows.insert(rows.size(), '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384},
                         1'b1, '{15'd0, 1'b1}});
        rows.insert(rows.size(), '{'{16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384},
                         1'b1, '{15'd0, 1'b0}});
        rows.insert(rows.size(), '{'{-16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384},
                         1'b1, '{15'd11520, 1'b0}});
        rows.insert(rows.size(), '{'{16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1},
                         1'b0, '{15'd0, 1'b0}});
        rows.insert(rows.size(), '{'{-16'sd32768, -16'sd32768, -16'sd32768,
                           16'sd32767, 16'sd32767, -16'sd32768}, 1'b0, '{15'd0, 1'b0}});
        rows.insert(rows.size(), '{'{16'sd32767, -16'sd32768, 16'sd32767,
                           -16'sd32768, 16'sd32767, 16'sd32767}, 1'b0, '{15'd0, 1'b0}});
        rows.insert(rows.size(), '{'{16'sd5, 16'sd3, 16'sd9, -16'sd32768, -16'sd32768,
                           -16'sd32768}, 1'b0, '{15'd0, 1'b0}});
        rows.insert(rows.size(), '{'{16'sd1, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384},
                         1'b0, '{15'd0, 1'b0}});
        rows.insert(rows.size(), '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0},
                         1'b0, '{15'd0, 1'b0}});
        rows.insert(rows.size(), '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0},
                         1'b0, '{15'd0, 1'b0}});
        rows.insert(rows.size(), '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0},
                         1'b0, '{15'd0, 1'b0}});
        rows.insert(rows.size(), '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1},
                         1'b0, '{15'd0, 1'b0}});
        foreach (rows[i])
        begin
            row = rows[i];
            send_pair(row.v, row.has_exp, row.r);
        end

        for (int n = 0; n < 400; )
        begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && n < 400; k++, n++)
                send_pair(rand_pair(), 1'b0, '{15'd0, 1'b0});
            if (n > 200 && n <= 220)
            begin
                // drain completely before resuming
                s_tvalid <= 1'b0;
                while (exp_bearings.size() != 0)
                    @(negedge clk);
            end
            else if ($urandom_range(0, 2) != 0)
                gap();
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stall pattern, with one long hold-off early on
    initial
    begin
        m_tready = 1'b0;
        long_hold = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        repeat (30) @(negedge clk);
        long_hold = 1'b1;
        repeat (80) @(negedge clk);
        long_hold = 1'b0;
        forever
        begin
            @(negedge clk);
            if (($urandom_range(0, 99) < 50) && (($urandom & 32'h300) != 0))
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0) && !long_hold;
        end
    end

    always @(posedge clk)
    begin
        bearing_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exp_bearings.size() == 0)
            begin
                $error("unexpected word: bearing %0d degenerate %0b", m_tdata[14:0], m_tuser);
                errors++;
            end
            else
            begin
                e = exp_bearings.pop_front();
                if (m_tdata[14:0] !== e.bearing)
                begin
                    $error("bearing: expected %0d actual %0d", e.bearing, m_tdata[14:0]);
                    errors++;
                end
                if (m_tuser !== e.degen)
                begin
                    $error("degenerate: expected %0b actual %0b", e.degen, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        fork
            begin
                wait (stim_done);
                while (exp_bearings.size() != 0)
                    @(posedge clk);
                repeat (40) @(posedge clk);
            end
            begin
                forever
                begin
                    @(posedge clk);
                    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                        idle_cycles = 0;
                    else
                        idle_cycles++;
                    if (idle_cycles >= WATCHDOG)
                        break;
                end
                errors++;
            end
        join_any
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
